// File: design/pc_parallel_port_controller_defines.svh
// ----------------------------------------------------------------------------
// Parallel port controller assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef PC_PARALLEL_PORT_CONTROLLER_DEFINES_SVH
`define PC_PARALLEL_PORT_CONTROLLER_DEFINES_SVH

// Same-cycle implication.
`define PC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pc assertion failed");

// Next-cycle implication.
`define PC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pc assertion failed");

`endif

// File: design/pc_pkg.sv
// ----------------------------------------------------------------------------
// Parallel port controller package
// Types, codes and constants shared by the controller modules.
// ----------------------------------------------------------------------------
package pc_pkg;

    localparam int NUM_PORTS_DEF = 4;
    localparam int CFG_W         = 3;

    localparam logic [7:0] STATUS_RST = 8'hC0;
    localparam logic [7:0] STATUS_INV = 8'hC0;
    localparam int         ACK_BIT    = 6;

    localparam logic [7:0] HI_PRIMARY   = 8'h03;
    localparam logic [7:0] HI_SECONDARY = 8'h02;
    localparam logic [5:0] LO_MONO      = 6'h2F;
    localparam logic [5:0] LO_STD       = 6'h1E;

    localparam logic [1:0] PORT_0 = 2'd0;
    localparam logic [1:0] PORT_1 = 2'd1;
    localparam logic [1:0] PORT_2 = 2'd2;

    localparam logic [1:0] OFS_DATA   = 2'd0;
    localparam logic [1:0] OFS_STATUS = 2'd1;
    localparam logic [1:0] OFS_CTRL   = 2'd2;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_TICK  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_DATA_WR,
        OP_CTRL_WR,
        OP_DATA_RD,
        OP_STAT_RD,
        OP_CTRL_RD,
        OP_TICK
    } t_op;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [1:0]  port_index;
        logic [7:0]  status_pins;
        logic [3:0]  control_pins;
    } t_req;

    typedef struct packed {
        logic       handled;
        logic [7:0] read_data;
        logic       data_out_valid;
        logic [7:0] data_out;
        logic       control_out_valid;
        logic [3:0] control_out;
        logic       irq_raise;
        logic       irq_lower;
        logic [1:0] irq_port;
    } t_rsp;

    typedef struct packed {
        logic       hit;
        logic [1:0] port;
        t_op        op;
    } t_dec;

    typedef struct packed {
        logic       sel;
        t_op        op;
        logic [7:0] wdata;
        logic [7:0] spins;
        logic [3:0] cpins;
    } t_unit_cmd;

    typedef struct packed {
        logic [7:0] read_data;
        logic       raise;
        logic       lower;
    } t_unit_rsp;

endpackage

// File: design/pc_item_ifs.sv
// ----------------------------------------------------------------------------
// Parallel port controller channels
// Request and result item channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [1:0]  port_index;
    logic [7:0]  status_pins;
    logic [3:0]  control_pins;

    modport source (output valid, kind, address, write_data, port_index, status_pins,
                    control_pins, input ready);
    modport sink (input valid, kind, address, write_data, port_index, status_pins,
                  control_pins, output ready);
endinterface

interface pc_rsp_if;
    logic       valid;
    logic       ready;
    logic       handled;
    logic [7:0] read_data;
    logic       data_out_valid;
    logic [7:0] data_out;
    logic       control_out_valid;
    logic [3:0] control_out;
    logic       irq_raise;
    logic       irq_lower;
    logic [1:0] irq_port;

    modport source (output valid, handled, read_data, data_out_valid, data_out,
                    control_out_valid, control_out, irq_raise, irq_lower, irq_port,
                    input ready);
    modport sink (input valid, handled, read_data, data_out_valid, data_out,
                  control_out_valid, control_out, irq_raise, irq_lower, irq_port,
                  output ready);
endinterface

// File: design/pc_addr_decode.sv
// ----------------------------------------------------------------------------
// Parallel port address decoder
// Maps an item to a present port and the register operation it performs.
// ----------------------------------------------------------------------------
module pc_addr_decode #(
    parameter int NUM_PORTS = pc_pkg::NUM_PORTS_DEF
) (
    input  pc_pkg::t_req              i_req,
    input  logic [pc_pkg::CFG_W-1:0]  i_num_ports,
    output pc_pkg::t_dec              o_dec
);

    logic [7:0]       hi;
    logic [5:0]       lo;
    logic [1:0]       offset;
    logic             addr_ok;
    logic [1:0]       addr_port;
    logic [1:0]       port;
    logic             present;
    pc_pkg::t_op      op;

    assign hi     = i_req.address[15:8];
    assign lo     = i_req.address[7:2];
    assign offset = i_req.address[1:0];

    always_comb begin
        addr_ok   = 1'b1;
        addr_port = pc_pkg::PORT_0;
        priority if (lo == pc_pkg::LO_MONO && hi == pc_pkg::HI_PRIMARY) begin
            addr_port = pc_pkg::PORT_2;
        end else if (lo == pc_pkg::LO_STD && hi == pc_pkg::HI_PRIMARY) begin
            addr_port = pc_pkg::PORT_0;
        end else if (lo == pc_pkg::LO_STD && hi == pc_pkg::HI_SECONDARY) begin
            addr_port = pc_pkg::PORT_1;
        end else begin
            addr_ok = 1'b0;
        end
    end

    always_comb begin
        op   = pc_pkg::OP_NONE;
        port = addr_port;
        unique case (pc_pkg::t_kind'(i_req.kind))
            pc_pkg::KIND_WRITE: begin
                if (addr_ok && offset == pc_pkg::OFS_DATA) begin
                    op = pc_pkg::OP_DATA_WR;
                end else if (addr_ok && offset == pc_pkg::OFS_CTRL) begin
                    op = pc_pkg::OP_CTRL_WR;
                end
            end
            pc_pkg::KIND_READ: begin
                if (addr_ok && offset == pc_pkg::OFS_DATA) begin
                    op = pc_pkg::OP_DATA_RD;
                end else if (addr_ok && offset == pc_pkg::OFS_STATUS) begin
                    op = pc_pkg::OP_STAT_RD;
                end else if (addr_ok && offset == pc_pkg::OFS_CTRL) begin
                    op = pc_pkg::OP_CTRL_RD;
                end
            end
            pc_pkg::KIND_TICK: begin
                op   = pc_pkg::OP_TICK;
                port = i_req.port_index;
            end
            default: begin
                op = pc_pkg::OP_NONE;
            end
        endcase
    end

    assign present = ({1'b0, port} < i_num_ports) &&
                     ({1'b0, port} < pc_pkg::CFG_W'(NUM_PORTS));

    always_comb begin
        o_dec.hit  = present && (op != pc_pkg::OP_NONE);
        o_dec.port = port;
        o_dec.op   = o_dec.hit ? op : pc_pkg::OP_NONE;
    end

endmodule

// File: design/pc_port_unit.sv
// ----------------------------------------------------------------------------
// Parallel port register cell
// Data latch, control bits, IRQ enable and state, and status of one port.
// ----------------------------------------------------------------------------
module pc_port_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  pc_pkg::t_unit_cmd     i_cmd,
    output pc_pkg::t_unit_rsp     o_rsp
);

    logic [7:0] r_data,   n_data;
    logic [1:0] r_ctrl,   n_ctrl;
    logic       r_irq_en, n_irq_en;
    logic [1:0] r_irq_st, n_irq_st;
    logic [7:0] r_status, n_status;

    logic [7:0] now;
    logic       ack_fall;
    logic       ack_rise;
    logic [1:0] smp_st;
    logic       smp_lower;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data   <= '0;
            r_ctrl   <= '0;
            r_irq_en <= 1'b0;
            r_irq_st <= '0;
            r_status <= pc_pkg::STATUS_RST;
        end else if (i_en) begin
            r_data   <= n_data;
            r_ctrl   <= n_ctrl;
            r_irq_en <= n_irq_en;
            r_irq_st <= n_irq_st;
            r_status <= n_status;
        end
    end

    assign now      = i_cmd.spins ^ pc_pkg::STATUS_INV;
    assign ack_fall = r_status[pc_pkg::ACK_BIT] && !now[pc_pkg::ACK_BIT];
    assign ack_rise = !r_status[pc_pkg::ACK_BIT] && now[pc_pkg::ACK_BIT];

    always_comb begin
        smp_st    = r_irq_st;
        smp_lower = 1'b0;
        priority if (ack_fall && r_irq_en) begin
            smp_st = r_irq_st | 2'b01;
        end else if (ack_rise || (!r_irq_en && r_irq_st != 2'b00)) begin
            smp_lower = r_irq_st[1];
            smp_st    = 2'b00;
        end else begin
            smp_st = r_irq_st;
        end
    end

    always_comb begin
        n_data   = r_data;
        n_ctrl   = r_ctrl;
        n_irq_en = r_irq_en;
        n_irq_st = r_irq_st;
        n_status = r_status;
        o_rsp    = '0;
        if (i_cmd.sel) begin
            unique case (i_cmd.op)
                pc_pkg::OP_DATA_WR: begin
                    n_data = i_cmd.wdata;
                end
                pc_pkg::OP_CTRL_WR: begin
                    n_status    = now;
                    n_irq_st    = smp_st;
                    o_rsp.lower = smp_lower;
                    n_ctrl      = i_cmd.wdata[5:4];
                    n_irq_en    = i_cmd.wdata[4];
                end
                pc_pkg::OP_TICK: begin
                    n_status    = now;
                    o_rsp.lower = smp_lower;
                    if (r_irq_en && smp_st == 2'b01) begin
                        o_rsp.raise = 1'b1;
                        n_irq_st    = 2'b11;
                    end else begin
                        n_irq_st = smp_st;
                    end
                end
                pc_pkg::OP_DATA_RD: begin
                    o_rsp.read_data = r_data;
                end
                pc_pkg::OP_STAT_RD: begin
                    o_rsp.read_data = {r_status[7:3], ~r_irq_st[1], r_status[1:0]};
                end
                pc_pkg::OP_CTRL_RD: begin
                    o_rsp.read_data = {2'b00, r_ctrl, ~i_cmd.cpins};
                end
                default: begin
                    o_rsp = '0;
                end
            endcase
        end
    end

endmodule

// File: design/pc_parallel_port_controller.sv
// ----------------------------------------------------------------------------
// Parallel port controller
// Up to four parallel port cells, ports 0 to 2 at 0x378, 0x278 and 0x3BC, with IRQ logic.
// ----------------------------------------------------------------------------
// The block accepts one item per clock unless a stalled result holds it, and
// returns one result item for each: an input register holds the item, the
// address decoder and the selected port cell work on it in one pass, and the
// result register presents the outcome. A stalled result holds the pipeline,
// and the input register keeps taking items as long as the result register
// drains. Write num_ports only while no item is in flight.
`include "pc_parallel_port_controller_defines.svh"

module pc_parallel_port_controller #(
    parameter int NUM_PORTS = pc_pkg::NUM_PORTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    pc_req_if.sink                     i_req,
    pc_rsp_if.source                   o_rsp,
    input  logic                       i_cfg_we,
    input  logic [pc_pkg::CFG_W-1:0]   i_cfg_wdata
);

    logic                      r_req_vld;
    pc_pkg::t_req              r_req;
    logic                      r_rsp_vld;
    pc_pkg::t_rsp              r_rsp, n_rsp;
    logic [pc_pkg::CFG_W-1:0]  r_num_ports;

    logic                      advance;
    pc_pkg::t_dec              dec;
    pc_pkg::t_unit_cmd         cmd [NUM_PORTS];
    pc_pkg::t_unit_rsp         unit_rsp [NUM_PORTS];
    pc_pkg::t_unit_rsp         merged;

    assign advance     = r_req_vld && (!r_rsp_vld || o_rsp.ready);
    assign i_req.ready = !r_req_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_ports <= '0;
        end else if (i_cfg_we) begin
            r_num_ports <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_req_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req.kind         <= i_req.kind;
            r_req.address      <= i_req.address;
            r_req.write_data   <= i_req.write_data;
            r_req.port_index   <= i_req.port_index;
            r_req.status_pins  <= i_req.status_pins;
            r_req.control_pins <= i_req.control_pins;
        end
    end

    pc_addr_decode #(
        .NUM_PORTS (NUM_PORTS)
    ) u_decode (
        .i_req       (r_req),
        .i_num_ports (r_num_ports),
        .o_dec       (dec)
    );

    for (genvar g = 0; g < NUM_PORTS; g++) begin : g_port
        always_comb begin
            cmd[g].sel   = dec.hit && (dec.port == 2'(g));
            cmd[g].op    = dec.op;
            cmd[g].wdata = r_req.write_data;
            cmd[g].spins = r_req.status_pins;
            cmd[g].cpins = r_req.control_pins;
        end

        pc_port_unit u_port (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (advance),
            .i_cmd   (cmd[g]),
            .o_rsp   (unit_rsp[g])
        );
    end

    always_comb begin
        merged = '0;
        for (int k = 0; k < NUM_PORTS; k++) begin
            merged = merged | unit_rsp[k];
        end
    end

    always_comb begin
        n_rsp                   = '0;
        n_rsp.handled           = dec.hit;
        n_rsp.read_data         = merged.read_data;
        n_rsp.irq_raise         = merged.raise;
        n_rsp.irq_lower         = merged.lower;
        n_rsp.irq_port          = dec.hit ? dec.port : 2'd0;
        n_rsp.data_out_valid    = (dec.op == pc_pkg::OP_DATA_WR);
        n_rsp.data_out          = (dec.op == pc_pkg::OP_DATA_WR) ? r_req.write_data : 8'd0;
        n_rsp.control_out_valid = (dec.op == pc_pkg::OP_CTRL_WR);
        n_rsp.control_out       = (dec.op == pc_pkg::OP_CTRL_WR) ?
                                  ~r_req.write_data[3:0] : 4'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_vld <= 1'b0;
        end else if (advance) begin
            r_rsp_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid             = r_rsp_vld;
    assign o_rsp.handled           = r_rsp.handled;
    assign o_rsp.read_data         = r_rsp.read_data;
    assign o_rsp.data_out_valid    = r_rsp.data_out_valid;
    assign o_rsp.data_out          = r_rsp.data_out;
    assign o_rsp.control_out_valid = r_rsp.control_out_valid;
    assign o_rsp.control_out       = r_rsp.control_out;
    assign o_rsp.irq_raise         = r_rsp.irq_raise;
    assign o_rsp.irq_lower         = r_rsp.irq_lower;
    assign o_rsp.irq_port          = r_rsp.irq_port;

    `PC_ASSERT_NEXT(a_advance_fills_rsp, advance, r_rsp_vld)
    `PC_ASSERT_IMPL(a_irq_exclusive, r_rsp_vld, !(r_rsp.irq_raise && r_rsp.irq_lower))
    `PC_ASSERT_IMPL(a_pins_need_handled,
        r_rsp_vld && (r_rsp.data_out_valid || r_rsp.control_out_valid), r_rsp.handled)
    `PC_ASSERT_IMPL(a_unhandled_quiet, r_rsp_vld && !r_rsp.handled,
        r_rsp.read_data == 8'd0 && r_rsp.irq_port == 2'd0 && !r_rsp.irq_raise)

endmodule

// File: tb/pc_parallel_port_controller_tb.sv
// ----------------------------------------------------------------------------
// Parallel port controller testbench
// Drives register accesses and status ticks through the request channel under
// random stalls on both sides. A scoreboard predicts every result item from its
// own model of the port registers and interrupt logic and checks them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class port_scoreboard;
    logic [7:0]    data_latch [4];
    logic [7:0]    ctrl_bits [4];
    logic          irq_en [4];
    logic [1:0]    irq_st [4];
    logic [7:0]    status [4];
    logic [2:0]    port_count;
    pc_pkg::t_rsp  pending_q [$];
    int            errors;
    int            items;
    int            results;
    int            handled_count;
    int            raises;
    int            lowers;

    function void clear_ports();
        for (int p = 0; p < 4; p++) begin
            data_latch[p] = '0;
            ctrl_bits[p] = '0;
            irq_en[p] = 1'b0;
            irq_st[p] = '0;
            status[p] = pc_pkg::STATUS_RST;
        end
        port_count = '0;
    endfunction

    function bit present(int p);
        return p < 4 && p < int'(port_count) && p < pc_pkg::NUM_PORTS_DEF;
    endfunction

    function int port_of(logic [15:0] addr);
        int p;
        p = 4;
        if (addr[15:8] == pc_pkg::HI_PRIMARY && addr[7:2] == pc_pkg::LO_MONO) p = 2;
        else if (addr[15:8] == pc_pkg::HI_PRIMARY && addr[7:2] == pc_pkg::LO_STD) p = 0;
        else if (addr[15:8] == pc_pkg::HI_SECONDARY && addr[7:2] == pc_pkg::LO_STD) p = 1;
        if (!present(p)) p = 4;
        return p;
    endfunction

    // Returns 1 when a raised interrupt is taken down by this sample.
    function bit sample(int p, logic [7:0] pins);
        logic [7:0] fresh;
        logic [7:0] diff;
        bit         lower;
        fresh = pins ^ pc_pkg::STATUS_INV;
        diff = fresh ^ status[p];
        lower = 1'b0;
        if (diff[pc_pkg::ACK_BIT] && status[p][pc_pkg::ACK_BIT] && irq_en[p]) begin
            irq_st[p][0] = 1'b1;
        end else if ((diff[pc_pkg::ACK_BIT] && fresh[pc_pkg::ACK_BIT]) ||
                     (!irq_en[p] && irq_st[p] != 2'b00)) begin
            lower = irq_st[p][1];
            irq_st[p] = 2'b00;
        end
        status[p] = fresh;
        return lower;
    endfunction

    function void note_request(pc_pkg::t_req r);
        pc_pkg::t_rsp e;
        int           p;
        e = '0;
        p = 4;
        unique case (r.kind)
            pc_pkg::KIND_WRITE: begin
                p = port_of(r.address);
                if (p < 4 && r.address[1:0] == pc_pkg::OFS_DATA) begin
                    data_latch[p] = r.write_data;
                    e.data_out_valid = 1'b1;
                    e.data_out = r.write_data;
                    e.handled = 1'b1;
                end else if (p < 4 && r.address[1:0] == pc_pkg::OFS_CTRL) begin
                    e.control_out_valid = 1'b1;
                    e.control_out = ~r.write_data[3:0];
                    e.irq_lower = sample(p, r.status_pins);
                    ctrl_bits[p] = r.write_data & 8'h30;
                    irq_en[p] = r.write_data[4];
                    e.handled = 1'b1;
                end
            end
            pc_pkg::KIND_READ: begin
                p = port_of(r.address);
                if (p < 4 && r.address[1:0] == pc_pkg::OFS_DATA) begin
                    e.read_data = data_latch[p];
                    e.handled = 1'b1;
                end else if (p < 4 && r.address[1:0] == pc_pkg::OFS_STATUS) begin
                    e.read_data = {status[p][7:3], ~irq_st[p][1], status[p][1:0]};
                    e.handled = 1'b1;
                end else if (p < 4 && r.address[1:0] == pc_pkg::OFS_CTRL) begin
                    e.read_data = {4'h0, ~r.control_pins} | ctrl_bits[p];
                    e.handled = 1'b1;
                end
            end
            pc_pkg::KIND_TICK: begin
                if (present(int'(r.port_index))) begin
                    p = int'(r.port_index);
                    e.irq_lower = sample(p, r.status_pins);
                    if (irq_en[p] && irq_st[p] == 2'b01) begin
                        e.irq_raise = 1'b1;
                        irq_st[p][1] = 1'b1;
                    end
                    e.handled = 1'b1;
                end
            end
            default: ;
        endcase
        if (e.handled) e.irq_port = 2'(p);
        items++;
        handled_count += int'(e.handled);
        raises += int'(e.irq_raise);
        lowers += int'(e.irq_lower);
        pending_q.push_back(e);
    endfunction

    function string show(pc_pkg::t_rsp r);
        return $sformatf({"hdl=%0b rd=%02h dv=%0b do=%02h cv=%0b co=%01h ",
                          "raise=%0b lower=%0b port=%0d"},
                         r.handled, r.read_data, r.data_out_valid, r.data_out,
                         r.control_out_valid, r.control_out, r.irq_raise, r.irq_lower,
                         r.irq_port);
    endfunction

    function void check_result(pc_pkg::t_rsp a);
        pc_pkg::t_rsp e;
        string        bad;
        results++;
        if (pending_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("Unexpected result item: %s", show(a));
            return;
        end
        e = pending_q.pop_front();
        bad = "";
        if (a.handled !== e.handled) bad = {bad, " handled"};
        if (a.read_data !== e.read_data) bad = {bad, " read_data"};
        if (a.data_out_valid !== e.data_out_valid) bad = {bad, " data_out_valid"};
        if (a.data_out !== e.data_out) bad = {bad, " data_out"};
        if (a.control_out_valid !== e.control_out_valid) bad = {bad, " control_out_valid"};
        if (a.control_out !== e.control_out) bad = {bad, " control_out"};
        if (a.irq_raise !== e.irq_raise) bad = {bad, " irq_raise"};
        if (a.irq_lower !== e.irq_lower) bad = {bad, " irq_lower"};
        if (a.irq_port !== e.irq_port) bad = {bad, " irq_port"};
        if (bad != "") begin
            errors++;
            if (errors <= 10) begin
                $display("Result %0d mismatch in%s", results, bad);
                $display("  expected %s", show(e));
                $display("  actual   %s", show(a));
            end
        end
    endfunction
endclass

module pc_parallel_port_controller_tb;
    localparam int         CFG_W      = pc_pkg::CFG_W;
    localparam logic [1:0] KIND_NONE  = 2'd3;
    localparam logic [1:0] OFS_UNUSED = 2'd3;
    localparam int         IDLE_PCT   = 38;
    localparam int         NUM_PHASES = 9;
    localparam int         PHASE_PORTS [NUM_PHASES] = '{4, 1, 0, 2, 7, 3, 5, 6, 4};
    localparam int         PHASE_ITEMS [NUM_PHASES] = '{150, 60, 30, 80, 120, 80, 60, 40, 130};

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    bit               calm;
    port_scoreboard   sb;

    pc_req_if req_if ();
    pc_rsp_if rsp_if ();

    pc_parallel_port_controller dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            rsp_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                sb.check_result(pc_pkg::t_rsp'{rsp_if.handled, rsp_if.read_data,
                                               rsp_if.data_out_valid, rsp_if.data_out,
                                               rsp_if.control_out_valid,
                                               rsp_if.control_out, rsp_if.irq_raise,
                                               rsp_if.irq_lower, rsp_if.irq_port});
            end
            if (req_if.valid && req_if.ready) begin
                sb.note_request(pc_pkg::t_req'{req_if.kind, req_if.address,
                                               req_if.write_data, req_if.port_index,
                                               req_if.status_pins, req_if.control_pins});
            end
        end
    end

    function automatic logic [15:0] port_addr(logic [1:0] sel, logic [1:0] ofs);
        unique case (sel)
            pc_pkg::PORT_0: return {pc_pkg::HI_PRIMARY, pc_pkg::LO_STD, ofs};
            pc_pkg::PORT_1: return {pc_pkg::HI_SECONDARY, pc_pkg::LO_STD, ofs};
            default:        return {pc_pkg::HI_PRIMARY, pc_pkg::LO_MONO, ofs};
        endcase
    endfunction

    function automatic pc_pkg::t_req make_item(logic [1:0] k, logic [15:0] a,
                                               logic [7:0] wd, logic [1:0] pi,
                                               logic [7:0] sp, logic [3:0] cp);
        pc_pkg::t_req r;
        r.kind = k;
        r.address = a;
        r.write_data = wd;
        r.port_index = pi;
        r.status_pins = sp;
        r.control_pins = cp;
        return r;
    endfunction

    // Mostly decoded accesses and ticks; the rest are near misses and noise.
    function automatic pc_pkg::t_req rand_item();
        pc_pkg::t_req r;
        int           roll;
        r = make_item(pc_pkg::KIND_TICK, 16'($urandom), 8'($urandom), 2'($urandom),
                      8'($urandom), 4'($urandom));
        roll = $urandom_range(0, 99);
        if (roll >= 35 && roll < 85) begin
            r.kind = (roll < 60) ? pc_pkg::KIND_WRITE : pc_pkg::KIND_READ;
            r.address = port_addr(2'($urandom_range(0, 2)), 2'($urandom));
        end else if (roll >= 85 && roll < 93) begin
            r.kind = 2'($urandom);
            r.address = port_addr(2'($urandom_range(0, 2)), 2'($urandom))
                        ^ (16'd1 << $urandom_range(0, 15));
        end else if (roll >= 93) begin
            r.kind = 2'($urandom);
        end
        return r;
    endfunction

    task automatic send_item(input pc_pkg::t_req r);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.kind <= r.kind;
        req_if.address <= r.address;
        req_if.write_data <= r.write_data;
        req_if.port_index <= r.port_index;
        req_if.status_pins <= r.status_pins;
        req_if.control_pins <= r.control_pins;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0) @(posedge clk);
    endtask

    task automatic set_ports(input logic [CFG_W-1:0] n);
        drain();
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= n;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.port_count = n;
    endtask

    initial begin
        sb = new;
        sb.clear_ports();
        calm = 1'b0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        req_if.valid <= 1'b0;
        req_if.kind <= '0;
        req_if.address <= '0;
        req_if.write_data <= '0;
        req_if.port_index <= '0;
        req_if.status_pins <= '0;
        req_if.control_pins <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // No port is present until the port count is written.
        send_item(make_item(pc_pkg::KIND_WRITE, port_addr(pc_pkg::PORT_0, pc_pkg::OFS_DATA),
                            8'hFF, 2'd0, 8'h00, 4'h0));
        send_item(make_item(pc_pkg::KIND_TICK, 16'h0000, 8'h00, 2'd0, 8'h40, 4'h0));

        set_ports(3'd4);
        send_item(make_item(pc_pkg::KIND_WRITE, port_addr(pc_pkg::PORT_0, pc_pkg::OFS_DATA),
                            8'hA5, 2'd0, 8'h00, 4'h0));
        send_item(make_item(pc_pkg::KIND_WRITE, port_addr(pc_pkg::PORT_1, pc_pkg::OFS_DATA),
                            8'h5A, 2'd0, 8'h00, 4'h0));
        send_item(make_item(pc_pkg::KIND_WRITE, port_addr(pc_pkg::PORT_2, pc_pkg::OFS_DATA),
                            8'hFF, 2'd0, 8'h00, 4'h0));
        send_item(make_item(pc_pkg::KIND_READ, port_addr(pc_pkg::PORT_0, pc_pkg::OFS_DATA),
                            8'h00, 2'd0, 8'h00, 4'h0));
        send_item(make_item(pc_pkg::KIND_READ, port_addr(pc_pkg::PORT_1, pc_pkg::OFS_DATA),
                            8'h00, 2'd0, 8'h00, 4'h0));
        send_item(make_item(pc_pkg::KIND_READ, port_addr(pc_pkg::PORT_2, pc_pkg::OFS_DATA),
                            8'h00, 2'd0, 8'h00, 4'h0));
        send_item(make_item(pc_pkg::KIND_READ, port_addr(pc_pkg::PORT_2, pc_pkg::OFS_STATUS),
                            8'h00, 2'd0, 8'h00, 4'h0));

        // Enable the interrupt, drop nACK to raise it, then let nACK rise again.
        send_item(make_item(pc_pkg::KIND_WRITE, port_addr(pc_pkg::PORT_0, pc_pkg::OFS_CTRL),
                            8'h3F, 2'd0, 8'hBF, 4'h0));
        send_item(make_item(pc_pkg::KIND_READ, port_addr(pc_pkg::PORT_0, pc_pkg::OFS_CTRL),
                            8'h00, 2'd0, 8'h00, 4'h0));
        send_item(make_item(pc_pkg::KIND_TICK, 16'hFFFF, 8'hFF, 2'd0, 8'h40, 4'hF));
        send_item(make_item(pc_pkg::KIND_READ, port_addr(pc_pkg::PORT_0, pc_pkg::OFS_STATUS),
                            8'h00, 2'd0, 8'h00, 4'h0));
        send_item(make_item(pc_pkg::KIND_TICK, 16'h0000, 8'h00, 2'd0, 8'h00, 4'h0));
        send_item(make_item(pc_pkg::KIND_TICK, 16'h0000, 8'h00, 2'd3, 8'hFF, 4'h0));

        // Raise on port 1, then disable so the next tick lowers the leftover state.
        send_item(make_item(pc_pkg::KIND_WRITE, port_addr(pc_pkg::PORT_1, pc_pkg::OFS_CTRL),
                            8'h10, 2'd0, 8'h00, 4'h0));
        send_item(make_item(pc_pkg::KIND_TICK, 16'h0000, 8'h00, 2'd1, 8'h40, 4'h0));
        send_item(make_item(pc_pkg::KIND_WRITE, port_addr(pc_pkg::PORT_1, pc_pkg::OFS_CTRL),
                            8'h00, 2'd0, 8'h40, 4'h0));
        send_item(make_item(pc_pkg::KIND_TICK, 16'h0000, 8'h00, 2'd1, 8'h40, 4'h0));

        send_item(make_item(pc_pkg::KIND_WRITE, port_addr(pc_pkg::PORT_0, pc_pkg::OFS_STATUS),
                            8'h77, 2'd0, 8'h00, 4'h0));
        send_item(make_item(pc_pkg::KIND_WRITE, port_addr(pc_pkg::PORT_0, OFS_UNUSED),
                            8'h77, 2'd0, 8'h00, 4'h0));
        send_item(make_item(pc_pkg::KIND_READ, port_addr(pc_pkg::PORT_2, OFS_UNUSED),
                            8'h00, 2'd0, 8'h00, 4'h0));
        send_item(make_item(KIND_NONE, 16'hFFFF, 8'hFF, 2'd3, 8'hFF, 4'hF));
        send_item(make_item(pc_pkg::KIND_WRITE, 16'hFFFF, 8'hFF, 2'd3, 8'hFF, 4'hF));
        send_item(make_item(pc_pkg::KIND_READ, 16'h0000, 8'h00, 2'd0, 8'h00, 4'h0));
        send_item(make_item(pc_pkg::KIND_READ, port_addr(pc_pkg::PORT_2, pc_pkg::OFS_CTRL),
                            8'h00, 2'd0, 8'h00, 4'hF));

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_ports(CFG_W'(PHASE_PORTS[ph]));
            for (int i = 0; i < PHASE_ITEMS[ph]; i++) begin
                calm = (ph == 0 && i >= 30 && i < 110);
                if (ph == 4 && i == 60) drain();
                send_item(rand_item());
            end
        end
        calm = 1'b0;

        drain();
        repeat (6) @(posedge clk);
        $display("Covered %0d items over port counts 0 to 7: %0d handled, %0d raises, %0d lowers.",
                 sb.items, sb.handled_count, sb.raises, sb.lowers);
        $display("Checked %0d result items, %0d failures.", sb.results, sb.errors);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// File: files.f
+incdir+design
design/pc_pkg.sv
design/pc_item_ifs.sv
design/pc_addr_decode.sv
design/pc_port_unit.sv
design/pc_parallel_port_controller.sv
tb/pc_parallel_port_controller_tb.sv
